### design/asmac_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive sliding-mode axis controller package
// Shared constants, controller states, datapath operations and the command
// and status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package asmac_pkg;

    localparam int NUM_AXES_DEF = 3;
    localparam int LIM_AXES     = 3;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 48;

    localparam logic [CFG_IW-1:0] REG_POS_LAST = 3'd5;
    localparam logic [CFG_IW-1:0] REG_SLEW     = 3'd6;

    localparam int WRAP_FULL = 92160;
    localparam int WRAP_HALF = 46080;
    localparam int EINT_MAX  = 5898240;
    localparam int GAIN_MIN  = 5120;
    localparam int GAIN_MAX  = 30720;
    localparam int DRIVE_MAX = 76800;
    localparam int S0_Q8     = 640;
    localparam int PHI_Q8    = 3072;
    localparam int SAT_ONE   = 65536;
    localparam int POS_LIMIT = 46080;

    localparam int RECIP3 = 43691;
    localparam int RECIP5 = 3355444;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_WRAP, S_MEI, S_EINT, S_P, S_MG, S_GAIN, S_MD3, S_Q3,
        S_MGS, S_URAW, S_MD5, S_Q5, S_MUD, S_STEP, S_MSD, S_POS, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_PASS, OP_WRAP, OP_EFIX, OP_MEI, OP_EINT, OP_P,
        OP_MG, OP_GAIN, OP_MD3, OP_Q3, OP_MGS, OP_URAW, OP_MD5, OP_Q5, OP_MUD,
        OP_STEP, OP_MSD, OP_POS
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic pass;
        logic wrap_ok;
    } t_dp_status;

endpackage

### design/asmac_ctrl.sv
// ----------------------------------------------------------------------------
// Adaptive sliding-mode axis controller sequencer
// Steps the datapath through one control update and handles both handshakes.
// ----------------------------------------------------------------------------
module asmac_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  asmac_pkg::t_dp_status i_status,
    output asmac_pkg::t_dp_cmd    o_cmd
);
    import asmac_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = i_in_valid ? S_CHECK : S_IDLE;
            S_CHECK: n_state = i_status.pass ? S_OUT : S_WRAP;
            S_WRAP:  n_state = i_status.wrap_ok ? S_MEI : S_WRAP;
            S_MEI:   n_state = S_EINT;
            S_EINT:  n_state = S_P;
            S_P:     n_state = S_MG;
            S_MG:    n_state = S_GAIN;
            S_GAIN:  n_state = S_MD3;
            S_MD3:   n_state = S_Q3;
            S_Q3:    n_state = S_MGS;
            S_MGS:   n_state = S_URAW;
            S_URAW:  n_state = S_MD5;
            S_MD5:   n_state = S_Q5;
            S_Q5:    n_state = S_MUD;
            S_MUD:   n_state = S_STEP;
            S_STEP:  n_state = S_MSD;
            S_MSD:   n_state = S_POS;
            S_POS:   n_state = S_OUT;
            S_OUT:   n_state = i_out_stall ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.op   = i_in_valid ? OP_CAPTURE : OP_NONE;
            end
            S_CHECK: o_cmd.op = i_status.pass ? OP_PASS : OP_NONE;
            S_WRAP:  o_cmd.op = i_status.wrap_ok ? OP_EFIX : OP_WRAP;
            S_MEI:   o_cmd.op = OP_MEI;
            S_EINT:  o_cmd.op = OP_EINT;
            S_P:     o_cmd.op = OP_P;
            S_MG:    o_cmd.op = OP_MG;
            S_GAIN:  o_cmd.op = OP_GAIN;
            S_MD3:   o_cmd.op = OP_MD3;
            S_Q3:    o_cmd.op = OP_Q3;
            S_MGS:   o_cmd.op = OP_MGS;
            S_URAW:  o_cmd.op = OP_URAW;
            S_MD5:   o_cmd.op = OP_MD5;
            S_Q5:    o_cmd.op = OP_Q5;
            S_MUD:   o_cmd.op = OP_MUD;
            S_STEP:  o_cmd.op = OP_STEP;
            S_MSD:   o_cmd.op = OP_MSD;
            S_POS:   o_cmd.op = OP_POS;
            S_OUT:   o_out_valid = 1'b1;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

### design/asmac_dp.sv
// ----------------------------------------------------------------------------
// Adaptive sliding-mode axis controller datapath
// Per-axis state, limit registers and one shared registered multiplier that
// carries every product and reciprocal division of the update.
// ----------------------------------------------------------------------------
module asmac_dp #(
    parameter int NUM_AXES = asmac_pkg::NUM_AXES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  asmac_pkg::t_dp_cmd            i_cmd,
    output asmac_pkg::t_dp_status         o_status,
    input  logic                          i_cfg_we,
    input  logic [asmac_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [asmac_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic [1:0]                    i_axis_index,
    input  logic signed [16:0]            i_measured_angle,
    input  logic signed [19:0]            i_angular_rate,
    input  logic signed [16:0]            i_reference_angle,
    input  logic [15:0]                   i_time_step,
    output logic signed [16:0]            o_position_command
);
    import asmac_pkg::*;

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic signed [16:0] r_lo [LIM_AXES];
    logic signed [16:0] r_hi [LIM_AXES];
    logic [47:0]        r_slew;

    logic signed [23:0] r_eint [NUM_AXES];
    logic [14:0]        r_gain [NUM_AXES];
    logic signed [17:0] r_fd   [NUM_AXES];
    logic signed [16:0] r_cmd  [NUM_AXES];
    logic [NUM_AXES-1:0] r_started;

    logic [1:0]         r_ax;
    logic signed [16:0] r_meas;
    logic signed [19:0] r_rate;
    logic [15:0]        r_dt;
    logic signed [19:0] r_e;
    logic signed [21:0] r_p;
    logic signed [21:0] r_s;
    logic [21:0]        r_y;
    logic               r_neg;
    logic signed [17:0] r_sat;
    logic signed [17:0] r_u;
    logic signed [17:0] r_step;
    logic signed [48:0] r_prod;
    logic signed [16:0] r_out;

    logic [AW-1:0]      w_ai;
    logic signed [16:0] w_lo, w_hi, w_cmd;
    logic [15:0]        w_slew;
    logic signed [23:0] w_eint;
    logic [14:0]        w_gain;
    logic signed [17:0] w_fd;
    logic signed [24:0] w_ma;
    logic signed [23:0] w_mb;
    logic signed [48:0] w_rp8, w_rp16;
    logic [21:0]        w_dt60;
    logic signed [48:0] w_esum;
    logic signed [23:0] w_eint_new;
    logic signed [23:0] w_eint_r7;
    logic signed [21:0] w_e22, w_p;
    logic signed [21:0] w_abs_s;
    logic signed [22:0] w_sm;
    logic signed [48:0] w_gsum;
    logic [14:0]        w_gain_new;
    logic [21:0]        w_q3, w_q5, w_qa3, w_qa5;
    logic [23:0]        w_t3, w_t5;
    logic signed [17:0] w_sat;
    logic signed [21:0] w_uraw;
    logic signed [22:0] w_x, w_absx;
    logic signed [22:0] w_uq;
    logic signed [17:0] w_u;
    logic signed [18:0] w_ms, w_st, w_pos;
    logic signed [16:0] w_pos_new;
    logic signed [16:0] w_seed;

    assign w_ai   = AW'(r_ax);
    assign w_lo   = r_lo[r_ax];
    assign w_hi   = r_hi[r_ax];
    assign w_slew = r_slew[{r_ax, 4'b0000} +: 16];
    assign w_eint = r_eint[w_ai];
    assign w_gain = r_gain[w_ai];
    assign w_fd   = r_fd[w_ai];
    assign w_cmd  = r_cmd[w_ai];

    assign o_status.pass    = (32'(r_ax) >= NUM_AXES) || (32'(r_ax) >= LIM_AXES)
                              || (r_dt == 16'd0);
    assign o_status.wrap_ok = (r_e >= 20'sd0) && (r_e < 20'(WRAP_FULL));
    assign o_position_command = r_out;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_MEI: begin
                w_ma = 25'(r_e);
                w_mb = {8'b0, r_dt};
            end
            OP_MG: begin
                w_ma = 25'(w_sm);
                w_mb = {2'b0, w_dt60};
            end
            OP_MD3: begin
                w_ma = {3'b0, r_y};
                w_mb = 24'(RECIP3);
            end
            OP_MD5: begin
                w_ma = {3'b0, r_y};
                w_mb = 24'(RECIP5);
            end
            OP_MGS: begin
                w_ma = 25'(r_sat);
                w_mb = {9'b0, w_gain};
            end
            OP_MUD: begin
                w_ma = 25'(r_u);
                w_mb = {8'b0, r_dt};
            end
            OP_MSD: begin
                w_ma = {9'b0, w_slew};
                w_mb = {8'b0, r_dt};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_rp8  = (r_prod + 49'sd128) >>> 8;
        w_rp16 = (r_prod + 49'sd32768) >>> 16;
        w_dt60 = {r_dt, 6'b0} - {4'b0, r_dt, 2'b0};

        w_esum = 49'(w_eint) + w_rp8;
        if (w_esum < -49'(EINT_MAX)) begin
            w_eint_new = -24'(EINT_MAX);
        end else if (w_esum > 49'(EINT_MAX)) begin
            w_eint_new = 24'(EINT_MAX);
        end else begin
            w_eint_new = w_esum[23:0];
        end

        w_eint_r7 = (w_eint + 24'sd64) >>> 7;
        w_e22     = 22'(r_e);
        w_p       = (w_e22 <<< 2) + (w_e22 <<< 1) + 22'(w_eint_r7);
        w_abs_s   = (r_s < 22'sd0) ? -r_s : r_s;
        w_sm      = 23'(w_abs_s) - 23'(S0_Q8);

        w_gsum = $signed({34'b0, w_gain}) + w_rp16;
        if (w_gsum < 49'(GAIN_MIN)) begin
            w_gain_new = 15'(GAIN_MIN);
        end else if (w_gsum > 49'(GAIN_MAX)) begin
            w_gain_new = 15'(GAIN_MAX);
        end else begin
            w_gain_new = w_gsum[14:0];
        end

        w_q3  = r_prod[38:17];
        w_t3  = {2'b0, r_y} - ({1'b0, w_q3, 1'b0} + {2'b0, w_q3});
        w_qa3 = w_t3[23] ? (w_q3 - 22'd1) : w_q3;
        if (r_s >= 22'(PHI_Q8)) begin
            w_sat = 18'(SAT_ONE);
        end else if (r_s <= -22'(PHI_Q8)) begin
            w_sat = -18'(SAT_ONE);
        end else if (r_s < 22'sd0) begin
            w_sat = -$signed(w_qa3[17:0]);
        end else begin
            w_sat = $signed(w_qa3[17:0]);
        end

        w_uraw = r_p + 22'(w_rp16);
        w_x    = (23'(w_fd) <<< 2) + 23'(w_uraw);
        w_absx = (w_x < 23'sd0) ? -w_x : w_x;

        w_q5  = r_prod[45:24];
        w_t5  = {2'b0, r_y} - ({w_q5, 2'b0} + {2'b0, w_q5});
        w_qa5 = w_t5[23] ? (w_q5 - 22'd1) : w_q5;
        w_uq  = r_neg ? -$signed({1'b0, w_qa5}) : $signed({1'b0, w_qa5});
        if (w_uq < -23'(DRIVE_MAX)) begin
            w_u = -18'(DRIVE_MAX);
        end else if (w_uq > 23'(DRIVE_MAX)) begin
            w_u = 18'(DRIVE_MAX);
        end else begin
            w_u = w_uq[17:0];
        end

        w_ms = 19'(w_rp16);
        if (19'(r_step) < -w_ms) begin
            w_st = -w_ms;
        end else if (19'(r_step) > w_ms) begin
            w_st = w_ms;
        end else begin
            w_st = 19'(r_step);
        end
        w_pos = 19'(w_cmd) + w_st;
        if (w_pos < 19'(w_lo)) begin
            w_pos_new = w_lo;
        end else if (w_pos > 19'(w_hi)) begin
            w_pos_new = w_hi;
        end else begin
            w_pos_new = w_pos[16:0];
        end

        if (r_meas < w_lo) begin
            w_seed = w_lo;
        end else if (r_meas > w_hi) begin
            w_seed = w_hi;
        end else begin
            w_seed = r_meas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIM_AXES; i++) begin
                r_lo[i] <= -17'(POS_LIMIT);
                r_hi[i] <= 17'(POS_LIMIT);
            end
            r_slew <= '1;
        end else if (i_cfg_we) begin
            if (i_cfg_index <= REG_POS_LAST) begin
                if (i_cfg_index[0]) begin
                    r_hi[i_cfg_index[2:1]] <= $signed(i_cfg_data[16:0]);
                end else begin
                    r_lo[i_cfg_index[2:1]] <= $signed(i_cfg_data[16:0]);
                end
            end else if (i_cfg_index == REG_SLEW) begin
                r_slew <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_eint[i] <= '0;
                r_gain[i] <= 15'(GAIN_MIN);
                r_fd[i]   <= '0;
                r_cmd[i]  <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_EFIX: begin
                    if (!r_started[w_ai]) begin
                        r_started[w_ai] <= 1'b1;
                        r_cmd[w_ai]     <= w_seed;
                    end
                end
                OP_EINT: r_eint[w_ai] <= w_eint_new;
                OP_GAIN: r_gain[w_ai] <= w_gain_new;
                OP_Q5:   r_fd[w_ai]   <= w_u;
                OP_POS:  r_cmd[w_ai]  <= w_pos_new;
                default: r_started    <= r_started;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_ax   <= i_axis_index;
                r_meas <= i_measured_angle;
                r_rate <= i_angular_rate;
                r_dt   <= i_time_step;
                r_e    <= 20'(i_reference_angle) - 20'(i_measured_angle) + 20'(WRAP_HALF);
            end
            OP_PASS: r_out <= r_meas;
            OP_WRAP: begin
                if (r_e < 20'sd0) begin
                    r_e <= r_e + 20'(WRAP_FULL);
                end else begin
                    r_e <= r_e - 20'(WRAP_FULL);
                end
            end
            OP_EFIX: r_e <= r_e - 20'(WRAP_HALF);
            OP_P: begin
                r_p <= w_p;
                r_s <= w_p - 22'(r_rate);
            end
            OP_GAIN: r_y <= {4'b0, w_abs_s[11:0], 6'b0} + 22'd1;
            OP_Q3:   r_sat <= w_sat;
            OP_URAW: begin
                r_neg <= w_x < 23'sd0;
                r_y   <= w_absx[21:0] + 22'd2;
            end
            OP_Q5:   r_u <= w_u;
            OP_STEP: r_step <= w_rp16[17:0];
            OP_POS:  r_out <= w_pos_new;
            default: r_out <= r_out;
        endcase
    end

endmodule

### design/adaptive_sliding_mode_axis_controller_top.sv
// ----------------------------------------------------------------------------
// Adaptive sliding-mode axis controller
// Three-axis fixed-point adaptive sliding-mode position controller.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A pass-through item (invalid axis or
// zero time step) is checked and its measured angle is registered as the
// result. A control update goes from the check through the wrap of the angle
// error and a sequence of steps in which every product and both rounding
// divisions go in turn through a single shared multiplier, then presents the
// result. The next item is taken once the result beat has been taken.
// Configuration writes are always accepted.
module adaptive_sliding_mode_axis_controller_top #(
    parameter int NUM_AXES = asmac_pkg::NUM_AXES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_axis_index,
    input  logic signed [16:0]            i_measured_angle,
    input  logic signed [19:0]            i_angular_rate,
    input  logic signed [16:0]            i_reference_angle,
    input  logic [15:0]                   i_time_step,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [16:0]            o_position_command,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [asmac_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [asmac_pkg::CFG_DW-1:0]  i_cfg_data
);
    import asmac_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    asmac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    asmac_dp #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_we           (i_cfg_valid & o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_axis_index       (i_axis_index),
        .i_measured_angle   (i_measured_angle),
        .i_angular_rate     (i_angular_rate),
        .i_reference_angle  (i_reference_angle),
        .i_time_step        (i_time_step),
        .o_position_command (o_position_command)
    );

endmodule

### design/asmac_checker.sv
// ----------------------------------------------------------------------------
// Adaptive sliding-mode axis controller checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module asmac_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result beat dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input not stalled after a beat was taken.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Input taken while a result is pending.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid straight after reset.");

endmodule

bind adaptive_sliding_mode_axis_controller_top asmac_checker u_asmac_checker (.*);
